@@ src/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// No dependencies; imported by every module of the block.
`default_nettype none

package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE    = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE      = 8'd32;
  localparam logic [CHAR_W-1:0] RESET_ATTRIBUTE = 8'd15;

  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_BACKSPACE = 2'd1,
    OP_CLEAR     = 2'd2,
    OP_READ      = 2'd3
  } op_t;

  typedef struct packed {
    logic wr_en;
    logic wr_blank;
    logic scroll;
  } cur_req_t;

endpackage

`default_nettype wire

@@ src/tcw_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on tcw_pkg for default sizes.
`default_nettype none

module tcw_ram
  import tcw_pkg::*;
#(
  parameter int WIDTH = CELL_W,
  parameter int DEPTH = DEF_ROWS * DEF_COLUMNS,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/tcw_cursor.sv @@
// Cursor registers (row, column, linear cell address) and their update per item.
// Depends on tcw_pkg for operation codes and the request struct.
`default_nettype none

module tcw_cursor
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  localparam int RW = $clog2(ROWS),
  localparam int CW = $clog2(COLUMNS),
  localparam int AW = $clog2(ROWS * COLUMNS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [1:0]        operation,
  input  wire logic [CHAR_W-1:0] char_code,
  output logic      [RW-1:0]     row_r,
  output logic      [CW-1:0]     col_r,
  output logic      [RW-1:0]     row_nxt,
  output logic      [CW-1:0]     col_nxt,
  output logic      [AW-1:0]     wr_addr,
  output cur_req_t               req
);

  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
  localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);

  logic [AW-1:0] addr_r;
  logic [AW-1:0] addr_nxt;
  logic          guard;

  assign guard = (col_r == CW'(1)) || (row_r == '0 && col_r == '0);

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    addr_nxt = addr_r;
    wr_addr  = addr_r;
    req      = '0;
    if (accept) begin
      unique case (op_t'(operation))
        OP_WRITE: begin
          if (char_code == NEWLINE_CODE) begin
            col_nxt = '0;
            if (row_r == LAST_ROW) begin
              req.scroll = 1'b1;
              addr_nxt   = LAST_BASE;
            end else begin
              row_nxt  = row_r + RW'(1);
              addr_nxt = addr_r - AW'(col_r) + COLS_A;
            end
          end else begin
            req.wr_en = 1'b1;
            if (col_r == LAST_COL) begin
              col_nxt = '0;
              if (row_r == LAST_ROW) begin
                req.scroll = 1'b1;
                addr_nxt   = LAST_BASE;
              end else begin
                row_nxt  = row_r + RW'(1);
                addr_nxt = addr_r + AW'(1);
              end
            end else begin
              col_nxt  = col_r + CW'(1);
              addr_nxt = addr_r + AW'(1);
            end
          end
        end
        OP_BACKSPACE: begin
          if (!guard) begin
            req.wr_en    = 1'b1;
            req.wr_blank = 1'b1;
            wr_addr      = addr_r - AW'(1);
            addr_nxt     = addr_r - AW'(1);
            if (col_r == '0) begin
              row_nxt = row_r - RW'(1);
              col_nxt = LAST_COL;
            end else begin
              col_nxt = col_r - CW'(1);
            end
          end
        end
        OP_CLEAR: begin
          row_nxt   = '0;
          col_nxt   = '0;
          addr_nxt  = '0;
        end
        OP_READ: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      addr_r <= '0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      addr_r <= addr_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(row_r) < ROWS)
    else $error("cursor row out of range");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(col_r) < COLUMNS)
    else $error("cursor column out of range");

  a_addr_match: assert property (@(posedge clk) disable iff (!rst_n)
    addr_r == AW'(int'(row_r) * COLUMNS + int'(col_r)))
    else $error("cursor address does not match row and column");
`endif

endmodule

`default_nettype wire

@@ src/text_console_writer.sv @@
// Text console writer: write char, newline and backspace leave busy low and register the
// result strobe for the cycle after start; an item that scrolls raises busy and strobes
// with out_scrolled at the end. Read cell strobes from the READ state with the store's
// registered read data. Results cannot be stalled. Clear and scroll keep busy high, one
// cell per cycle through the single write port. After reset a clearing pass fills the
// store with spaces at attribute 15 while busy is high; config writes are always accepted.
`default_nettype none

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_operation,
  input  wire logic [CHAR_W-1:0] in_char_code,
  input  wire logic [ROW_W-1:0]  in_read_row,
  input  wire logic [COL_W-1:0]  in_read_col,
  output logic                   out_strobe,
  output logic      [ROW_W-1:0]  out_cursor_row,
  output logic      [COL_W-1:0]  out_cursor_col,
  output logic      [CHAR_W-1:0] out_cell_char,
  output logic      [CHAR_W-1:0] out_cell_attribute,
  output logic                   out_scrolled,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CHAR_W-1:0] cfg_text_attribute
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_COPY, S_FILL} state_t;

  state_t            state_r;
  logic [AW-1:0]     cnt_r;
  logic [CHAR_W-1:0] attr_r;
  logic [CHAR_W-1:0] fill_attr_r;
  logic              fill_rep_r;
  logic              scr_r;
  logic              rd_ok_r;

  logic              out_strobe_r;
  logic [ROW_W-1:0]  out_cursor_row_r;
  logic [COL_W-1:0]  out_cursor_col_r;
  logic [CHAR_W-1:0] out_cell_char_r;
  logic [CHAR_W-1:0] out_cell_attr_r;
  logic              out_scrolled_r;

  logic              accept;
  logic              rd_ok;
  logic [AW-1:0]     rd_addr;
  logic [RW-1:0]     row_r;
  logic [CW-1:0]     col_r;
  logic [RW-1:0]     row_nxt;
  logic [CW-1:0]     col_nxt;
  logic [AW-1:0]     cur_wr_addr;
  cur_req_t          req;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign rd_ok   = (32'(in_read_row) < ROWS) && (32'(in_read_col) < COLUMNS);
  assign rd_addr = AW'(32'(in_read_row) * COLUMNS + 32'(in_read_col));

  tcw_cursor #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_cursor (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .operation(in_operation),
    .char_code(in_char_code),
    .row_r    (row_r),
    .col_r    (col_r),
    .row_nxt  (row_nxt),
    .col_nxt  (col_nxt),
    .wr_addr  (cur_wr_addr),
    .req      (req)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = {fill_attr_r, SPACE_CODE};
    ram_raddr = rd_addr;
    unique case (state_r)
      S_IDLE: begin
        ram_we    = req.wr_en;
        ram_waddr = cur_wr_addr;
        ram_wdata = {attr_r, (req.wr_blank ? SPACE_CODE : in_char_code)};
      end
      S_READ: begin
      end
      S_COPY: begin
        ram_raddr = cnt_r + COLS_A;
        ram_we    = (cnt_r != '0);
        ram_waddr = cnt_r - AW'(1);
        ram_wdata = ram_rdata;
      end
      S_FILL: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= RESET_ATTRIBUTE;
    end else if (cfg_valid && cfg_ready) begin
      attr_r <= cfg_text_attribute;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_FILL;
      cnt_r        <= '0;
      fill_attr_r  <= RESET_ATTRIBUTE;
      fill_rep_r   <= 1'b0;
      scr_r        <= 1'b0;
      rd_ok_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (op_t'(in_operation))
              OP_WRITE, OP_BACKSPACE: begin
                if (req.scroll) begin
                  state_r <= S_COPY;
                  cnt_r   <= '0;
                  scr_r   <= 1'b1;
                end else begin
                  out_strobe_r     <= 1'b1;
                  out_cursor_row_r <= ROW_W'(row_nxt);
                  out_cursor_col_r <= COL_W'(col_nxt);
                  out_cell_char_r  <= '0;
                  out_cell_attr_r  <= '0;
                  out_scrolled_r   <= 1'b0;
                end
              end
              OP_CLEAR: begin
                state_r     <= S_FILL;
                cnt_r       <= '0;
                fill_attr_r <= attr_r;
                fill_rep_r  <= 1'b1;
                scr_r       <= 1'b0;
              end
              OP_READ: begin
                state_r <= S_READ;
                rd_ok_r <= rd_ok;
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          state_r          <= S_IDLE;
          out_strobe_r     <= 1'b1;
          out_cursor_row_r <= ROW_W'(row_r);
          out_cursor_col_r <= COL_W'(col_r);
          out_cell_char_r  <= rd_ok_r ? ram_rdata[CHAR_W-1:0] : '0;
          out_cell_attr_r  <= rd_ok_r ? ram_rdata[CELL_W-1:CHAR_W] : '0;
          out_scrolled_r   <= 1'b0;
        end
        S_COPY: begin
          if (cnt_r == LAST_BASE) begin
            state_r     <= S_FILL;
            fill_attr_r <= attr_r;
            fill_rep_r  <= 1'b1;
          end else begin
            cnt_r <= cnt_r + AW'(1);
          end
        end
        S_FILL: begin
          if (cnt_r == LAST_ADDR) begin
            state_r <= S_IDLE;
            if (fill_rep_r) begin
              out_strobe_r     <= 1'b1;
              out_cursor_row_r <= ROW_W'(row_r);
              out_cursor_col_r <= COL_W'(col_r);
              out_cell_char_r  <= '0;
              out_cell_attr_r  <= '0;
              out_scrolled_r   <= scr_r;
            end
          end else begin
            cnt_r <= cnt_r + AW'(1);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_cursor_row     = out_cursor_row_r;
  assign out_cursor_col     = out_cursor_col_r;
  assign out_cell_char      = out_cell_char_r;
  assign out_cell_attribute = out_cell_attr_r;
  assign out_scrolled       = out_scrolled_r;

`ifndef ASSERT_OFF
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> state_r == S_IDLE)
    else $error("result issued while the engine is still busy");

  a_scroll_home: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_scrolled_r) |-> out_cursor_col_r == '0)
    else $error("scroll result with cursor away from column zero");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> cnt_r <= LAST_ADDR)
    else $error("fill address beyond the screen");

  a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COPY |-> cnt_r <= LAST_BASE)
    else $error("scroll copy address beyond the last row base");

  a_copy_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY && $past(state_r) == S_COPY) |-> cnt_r == $past(cnt_r) + AW'(1))
    else $error("scroll copy skipped or repeated a cell");
`endif

endmodule

`default_nettype wire
